### rtl/core/hnm_pkg.sv
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared constants and types of the height to normal map core.
// ----------------------------------------------------------------------------
package hnm_pkg;

	localparam int MaxWidth  = 4096;
	localparam int MaxHeight = 4096;
	localparam int AddrW     = $clog2(MaxWidth);
	localparam int CfgW      = 13;
	localparam int CfgIdxW   = 2;

	localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_SQX,
		ST_SQY,
		ST_CSQ,
		ST_RHS,
		ST_MSQ,
		ST_MUL,
		ST_CMP,
		ST_PUSH
	} hnm_state_t;

endpackage

### rtl/core/height_to_normal_map_core.sv
// ----------------------------------------------------------------------------
// height_to_normal_map_core
// Central difference normal map from a raster stream of 8-bit heights.
// ----------------------------------------------------------------------------
// One height beat is taken at a time. The line buffer is read in the accept
// cycle and in RD1 and written back in RD2. Each result the beat causes (none
// on the first row, one on the other rows, up to three on the last row) then
// goes through the shared squaring / multiply / compare unit: the squared
// length, then per component the reference term plus an 8-step bisection of
// square, multiply and compare, and last the load of the output register.
// in_stall is high in every state but IDLE, so also while a result waits for
// the output register to free up under out_stall. Results leave through an
// output register, so the next height beat is taken while the last result
// still waits on out_stall.
// Results lag the input by one row; the last row is flushed as it streams in.
// A write to the width or height register restarts the frame at pixel (0,0).
// ----------------------------------------------------------------------------
module height_to_normal_map_core
	import hnm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         normal_x,
	output logic [7:0]         normal_y,
	output logic [7:0]         normal_z,
	output logic [11:0]        out_col,
	output logic [11:0]        out_row,
	output logic               last_of_run,
	output logic               end_of_frame
);

	// configuration and position
	logic [CfgW-1:0]  width_q, height_q;
	logic [AddrW-1:0] col_q, row_q;
	logic [CfgW-1:0]  w_eff, h_eff;
	logic [AddrW-1:0] x_in, y_in;

	// per beat registers
	hnm_state_t       state_q, state_d;
	logic [AddrW-1:0] x_q, y_q;
	logic [7:0]       h_q, rp0_q, rp1_q, rp2_q;
	logic [7:0]       p0_q, p1_q, s0_q, sm_q;
	logic             has_r_q, has_l_q, has_u_q, has_l2_q;
	logic [2:0]       mask_q;
	logic [1:0]       idx_q;

	// line buffers
	logic [7:0]       prev_mem   [MaxWidth];
	logic [7:0]       second_mem [MaxWidth];
	logic [AddrW-1:0] prev_addr, second_addr;
	logic             mem_we;
	logic [7:0]       prev_rd, second_rd;

	// arithmetic unit
	logic [17:0]      sq_q, csq_q;
	logic [19:0]      len_q;
	logic [35:0]      rhs_q, lhs_q;
	logic [13:0]      msq_q;
	logic [7:0]       res_q, bit_q, nx_q, ny_q;
	logic [1:0]       comp_q;

	logic             accept, cfg_hit, is_last_row, push_ok;
	logic [2:0]       mask_left;

	// clamp sizes to 2..MaxWidth / 2..MaxHeight
	always_comb begin
		w_eff = width_q;
		if (width_q < CfgW'(2)) w_eff = CfgW'(2);
		else if (width_q > CfgW'(MaxWidth)) w_eff = CfgW'(MaxWidth);
		h_eff = height_q;
		if (height_q < CfgW'(2)) h_eff = CfgW'(2);
		else if (height_q > CfgW'(MaxHeight)) h_eff = CfgW'(MaxHeight);
	end

	// an out of range counter counts as zero
	assign x_in = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
	assign y_in = ({1'b0, row_q} >= h_eff) ? '0 : row_q;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign cfg_hit     = cfg_wr_en &&
	                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
	assign is_last_row = ({1'b0, y_in} == h_eff - CfgW'(1));
	assign push_ok     = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CfgW'(512);
			height_q <= CfgW'(512);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == REG_IMAGE_WIDTH) width_q <= cfg_data;
			else height_q <= cfg_data;
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if ({1'b0, x_in} + CfgW'(1) >= w_eff) begin
				col_q <= '0;
				row_q <= ({1'b0, y_in} + CfgW'(1) >= h_eff) ? '0 : y_in + AddrW'(1);
			end else begin
				col_q <= x_in + AddrW'(1);
			end
		end
	end

	// line buffer ports: read center pair, then the neighbors, then write back
	always_comb begin
		prev_addr   = x_in;
		second_addr = x_in;
		mem_we      = 1'b0;
		case (state_q)
			ST_RD1: begin
				prev_addr   = x_q + AddrW'(1);
				second_addr = x_q - AddrW'(1);
			end
			ST_RD2: begin
				prev_addr   = x_q;
				second_addr = x_q;
				mem_we      = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) prev_mem[prev_addr] <= h_q;
		prev_rd <= prev_mem[prev_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we) second_mem[second_addr] <= p0_q;
		second_rd <= second_mem[second_addr];
	end

	// operands of the result being worked on
	logic [7:0] op_l, op_r, op_u, op_d;
	always_comb begin
		case (idx_q)
			2'd0: begin
				op_l = has_l_q ? sm_q : p0_q;
				op_r = has_r_q ? p1_q : p0_q;
				op_u = has_u_q ? s0_q : p0_q;
				op_d = h_q;
			end
			2'd1: begin
				op_l = has_l2_q ? rp2_q : rp1_q;
				op_r = rp0_q;
				op_u = sm_q;
				op_d = rp1_q;
			end
			default: begin
				op_l = rp1_q;
				op_r = rp0_q;
				op_u = p0_q;
				op_d = rp0_q;
			end
		endcase
	end

	logic signed [9:0]  dl, du, dx2, dy2, c2;
	logic signed [19:0] dxsq, dysq, csq;
	logic [7:0]         trial;
	logic signed [7:0]  m;
	logic signed [15:0] msq;
	logic               m_pos, ok;

	assign dl    = $signed({2'b00, op_l}) - $signed({2'b00, op_r});
	assign du    = $signed({2'b00, op_u}) - $signed({2'b00, op_d});
	assign dx2   = dl <<< 1;
	assign dy2   = du <<< 1;
	assign dxsq  = dx2 * dx2;
	assign dysq  = dy2 * dy2;
	assign c2    = (comp_q == 2'd0) ? dx2 : (comp_q == 2'd1) ? dy2 : 10'sd51;
	assign csq   = c2 * c2;
	assign trial = res_q | bit_q;
	assign m     = $signed(trial ^ 8'h80);        // trial - 128
	assign msq   = m * m;
	assign m_pos = trial[7] && (trial[6:0] != 7'd0);

	// 2(k-128)*sqrt(L) <= 255*c2, squared with sign cases split out
	always_comb begin
		if (!m_pos && !c2[9]) ok = 1'b1;
		else if (m_pos && c2[9]) ok = 1'b0;
		else if (m_pos) ok = (lhs_q <= rhs_q);
		else ok = (lhs_q >= rhs_q);
	end

	assign mask_left = mask_q & ~(3'b001 << idx_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_RD1;
			ST_RD1:  state_d = ST_RD2;
			ST_RD2:  state_d = (mask_q == 3'd0) ? ST_IDLE : ST_SQX;
			ST_SQX:  state_d = ST_SQY;
			ST_SQY:  state_d = ST_CSQ;
			ST_CSQ:  state_d = ST_RHS;
			ST_RHS:  state_d = ST_MSQ;
			ST_MSQ:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_CMP;
			ST_CMP: begin
				if (!bit_q[0]) state_d = ST_MSQ;
				else if (comp_q == 2'd2) state_d = ST_PUSH;
				else state_d = ST_CSQ;
			end
			ST_PUSH: begin
				if (push_ok) state_d = (mask_left == 3'd0) ? ST_IDLE : ST_SQX;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// recent samples of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp0_q <= '0;
			rp1_q <= '0;
			rp2_q <= '0;
		end else if (accept) begin
			rp2_q <= rp1_q;
			rp1_q <= rp0_q;
			rp0_q <= height;
		end
	end

	// beat capture and the arithmetic sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			idx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mask_q[0] <= (y_in != '0);
						mask_q[1] <= is_last_row && (x_in != '0);
						mask_q[2] <= is_last_row && ({1'b0, x_in} == w_eff - CfgW'(1));
					end
				end
				ST_RD2: begin
					idx_q <= mask_q[0] ? 2'd0 : mask_q[1] ? 2'd1 : 2'd2;
				end
				ST_PUSH: begin
					if (push_ok) begin
						mask_q <= mask_left;
						idx_q  <= mask_left[1] ? 2'd1 : 2'd2;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q      <= x_in;
				y_q      <= y_in;
				h_q      <= height;
				has_l_q  <= (x_in != '0);
				has_l2_q <= (x_in > AddrW'(1));
				has_u_q  <= (y_in > AddrW'(1));
				has_r_q  <= ({1'b0, x_in} + CfgW'(1) < w_eff);
			end
			ST_RD1: begin
				p0_q <= prev_rd;
				s0_q <= second_rd;
			end
			ST_RD2: begin
				p1_q <= prev_rd;
				sm_q <= second_rd;
			end
			ST_SQX: sq_q <= dxsq[17:0];
			ST_SQY: begin
				len_q  <= 20'(sq_q) + 20'(dysq[17:0]) + 20'd2601;
				comp_q <= '0;
			end
			ST_CSQ: begin
				csq_q <= csq[17:0];
				res_q <= '0;
				bit_q <= 8'h80;
			end
			ST_RHS: rhs_q <= 36'(csq_q) * 36'd65025;
			ST_MSQ: msq_q <= msq[13:0];
			ST_MUL: lhs_q <= (36'(msq_q) * 36'(len_q)) << 2;
			ST_CMP: begin
				if (ok) res_q <= trial;
				bit_q <= bit_q >> 1;
				if (bit_q[0]) begin
					if (comp_q == 2'd0) nx_q <= ok ? trial : res_q;
					if (comp_q == 2'd1) ny_q <= ok ? trial : res_q;
					comp_q <= comp_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (state_q == ST_PUSH && push_ok) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && push_ok) begin
			normal_x     <= nx_q;
			normal_y     <= ny_q;
			normal_z     <= res_q;
			out_col      <= (idx_q == 2'd1) ? x_q - AddrW'(1) : x_q;
			out_row      <= (idx_q == 2'd0) ? y_q - AddrW'(1) : y_q;
			last_of_run  <= (mask_left == 3'd0);
			end_of_frame <= (idx_q == 2'd2);
		end
	end

endmodule
